>>> sv/erm_pkg.sv
`timescale 1ns / 1ps
package erm_pkg;
	localparam int ANGLE_BITS   = 16;
	localparam int FRAC_BITS    = 16;
	localparam int OUT_W        = FRAC_BITS + 2;
	localparam int CORDIC_STEPS = 30;
	// CORDIC datapath width, trig result width (Q30), element sum width
	localparam int CW = 34;
	localparam int TW = 32;
	localparam int EW = 34;
	localparam int RND_SH = 30 - FRAC_BITS;
	localparam longint RND = (RND_SH > 0) ? (64'sd1 <<< (RND_SH - 1)) : 64'sd0;
	// sincos: input reg + one reg per step + output reg; matrix: four stages
	localparam int SC_LAT = CORDIC_STEPS + 2;
	localparam int LAT    = SC_LAT + 4;
	localparam logic signed [CW-1:0] X_INIT = 34'sd652032874;

	localparam logic signed [CW-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
		34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
		34'sd42667331, 34'sd21354465, 34'sd10680862, 34'sd5340245,
		34'sd2670163, 34'sd1335087, 34'sd667544, 34'sd333772, 34'sd166886,
		34'sd83443, 34'sd41722, 34'sd20861, 34'sd10430, 34'sd5215, 34'sd2608,
		34'sd1304, 34'sd652, 34'sd326, 34'sd163, 34'sd81, 34'sd41, 34'sd20,
		34'sd10, 34'sd5, 34'sd3, 34'sd1
	};

	typedef enum logic [1:0] {
		OP_ROT    = 2'd0,
		OP_DYAW   = 2'd1,
		OP_DPITCH = 2'd2,
		OP_DROLL  = 2'd3
	} op_t;
endpackage

>>> sv/erm_in_if.sv
`timescale 1ns / 1ps
interface erm_in_if;
	logic valid;
	logic ready;
	logic [1:0] operation;
	logic signed [erm_pkg::ANGLE_BITS-1:0] yaw;
	logic signed [erm_pkg::ANGLE_BITS-1:0] pitch;
	logic signed [erm_pkg::ANGLE_BITS-1:0] roll;
	modport source (output valid, operation, yaw, pitch, roll, input ready);
	modport sink (input valid, operation, yaw, pitch, roll, output ready);
endinterface

>>> sv/erm_out_if.sv
`timescale 1ns / 1ps
interface erm_out_if;
	logic valid;
	logic ready;
	logic signed [erm_pkg::OUT_W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
	modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
		input ready);
	modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
		output ready);
endinterface

>>> sv/euler_rotation_matrix_unit.sv
`timescale 1ns / 1ps
// Z-Y-X Euler rotation matrix unit (navigation frame to body frame).
// Input channel "angles": one request carries an operation code (rotation
// matrix, or its derivative by yaw, pitch or roll) and three signed binary
// angles (full circle 2^ANGLE_BITS).
// Output channel "matrix": the nine row-major elements, signed Q2.FRAC_BITS,
// rounded and saturated.
// Pipeline: 36 register stages - 32 in each of the three parallel unrolled
// CORDIC pipelines (30 steps plus input and output registers), then four in
// the product/sum/round pipeline.
// Throughput: one request per cycle while the pipeline is not stalled; every stage holds one request.
// Stall: the whole pipeline moves on one enable. While the result register
// holds a valid result that is not taken, the pipeline freezes and
// angles.ready drops; nothing is lost or repeated. While the result register
// is empty the pipeline keeps moving, whatever the receiver does.
// Reset clears the valid bits only; no state survives between requests.
module euler_rotation_matrix_unit (
	input  logic clk,
	input  logic arst_n,
	erm_in_if.sink    angles,
	erm_out_if.source matrix
);
	logic [erm_pkg::LAT-1:0] vld_q;
	erm_pkg::op_t op_q [erm_pkg::LAT];
	logic adv;
	logic signed [erm_pkg::TW-1:0] sy, cy, sp, cp, sr, cr;
	logic signed [erm_pkg::OUT_W-1:0] m_res [9];

	// single pipeline enable: move unless the result is held
	assign adv = !vld_q[erm_pkg::LAT-1] || matrix.ready;
	assign angles.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[erm_pkg::LAT-2:0], angles.valid};
		end
	end

	// op travels with the request (kept to the end for checking)
	always_ff @(posedge clk) begin
		if (adv) begin
			op_q[0] <= erm_pkg::op_t'(angles.operation);
			for (int k = 1; k < erm_pkg::LAT; k++)
				op_q[k] <= op_q[k-1];
		end
	end

	erm_sincos u_yaw (.clk(clk), .en(adv), .angle(angles.yaw), .sin_q(sy), .cos_q(cy));
	erm_sincos u_pitch (.clk(clk), .en(adv), .angle(angles.pitch), .sin_q(sp), .cos_q(cp));
	erm_sincos u_roll (.clk(clk), .en(adv), .angle(angles.roll), .sin_q(sr), .cos_q(cr));

	erm_matrix u_matrix (
		.clk(clk), .en(adv), .op(op_q[erm_pkg::SC_LAT-1]),
		.sy(sy), .cy(cy), .sp(sp), .cp(cp), .sr(sr), .cr(cr),
		.m(m_res)
	);

	assign matrix.valid = vld_q[erm_pkg::LAT-1];
	assign matrix.m00 = m_res[0];
	assign matrix.m01 = m_res[1];
	assign matrix.m02 = m_res[2];
	assign matrix.m10 = m_res[3];
	assign matrix.m11 = m_res[4];
	assign matrix.m12 = m_res[5];
	assign matrix.m20 = m_res[6];
	assign matrix.m21 = m_res[7];
	assign matrix.m22 = m_res[8];

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(angles.valid && angles.ready) |=> vld_q[0])
		else $error("accepted request missing from first stage");

	a_stall_freezes: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_q))
		else $error("pipeline moved while stalled");

	a_droll_row0: assert property (@(posedge clk) disable iff (!arst_n)
		(matrix.valid && op_q[erm_pkg::LAT-1] == erm_pkg::OP_DROLL) |->
		(matrix.m00 == '0 && matrix.m01 == '0 && matrix.m02 == '0))
		else $error("d/droll row 0 not zero");

	a_dyaw_col2: assert property (@(posedge clk) disable iff (!arst_n)
		(matrix.valid && op_q[erm_pkg::LAT-1] == erm_pkg::OP_DYAW) |->
		(matrix.m02 == '0 && matrix.m12 == '0 && matrix.m22 == '0))
		else $error("d/dyaw column 2 not zero");
endmodule

>>> sv/erm_sincos.sv
`timescale 1ns / 1ps
// Fully unrolled rotation-mode CORDIC, one register stage per step.
module erm_sincos (
	input  logic clk,
	input  logic en,
	input  logic signed [erm_pkg::ANGLE_BITS-1:0] angle,
	output logic signed [erm_pkg::TW-1:0] sin_q,
	output logic signed [erm_pkg::TW-1:0] cos_q
);
	logic signed [erm_pkg::CW-1:0] x_s [erm_pkg::CORDIC_STEPS+1];
	logic signed [erm_pkg::CW-1:0] y_s [erm_pkg::CORDIC_STEPS+1];
	logic signed [erm_pkg::CW-1:0] z_s [erm_pkg::CORDIC_STEPS+1];
	logic flip_s [erm_pkg::CORDIC_STEPS+1];
	logic [31:0] turn;
	logic flip;
	logic [31:0] turn_f;

	always_comb begin
		turn   = 32'(angle) << (32 - erm_pkg::ANGLE_BITS);
		flip   = turn[31] ^ turn[30];
		turn_f = {turn[31] ^ flip, turn[30:0]};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]    <= erm_pkg::X_INIT;
			y_s[0]    <= '0;
			z_s[0]    <= erm_pkg::CW'($signed(turn_f));
			flip_s[0] <= flip;
			for (int i = 0; i < erm_pkg::CORDIC_STEPS; i++) begin
				flip_s[i+1] <= flip_s[i];
				if (!z_s[i][erm_pkg::CW-1]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - erm_pkg::ATAN_TURNS[i];
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + erm_pkg::ATAN_TURNS[i];
				end
			end
			if (flip_s[erm_pkg::CORDIC_STEPS]) begin
				cos_q <= erm_pkg::TW'(-x_s[erm_pkg::CORDIC_STEPS]);
				sin_q <= erm_pkg::TW'(-y_s[erm_pkg::CORDIC_STEPS]);
			end else begin
				cos_q <= erm_pkg::TW'(x_s[erm_pkg::CORDIC_STEPS]);
				sin_q <= erm_pkg::TW'(y_s[erm_pkg::CORDIC_STEPS]);
			end
		end
	end
endmodule

>>> sv/erm_matrix.sv
`timescale 1ns / 1ps
// Products (two stages), element select and sum, round and saturate.
module erm_matrix (
	input  logic clk,
	input  logic en,
	input  erm_pkg::op_t op,
	input  logic signed [erm_pkg::TW-1:0] sy, cy, sp, cp, sr, cr,
	output logic signed [erm_pkg::OUT_W-1:0] m [9]
);
	function automatic logic signed [erm_pkg::TW-1:0] qmul(
		input logic signed [erm_pkg::TW-1:0] a, input logic signed [erm_pkg::TW-1:0] b);
		logic signed [63:0] p;
		p = (64'(a) * 64'(b) + 64'sd536870912) >>> 30;
		return p[erm_pkg::TW-1:0];
	endfunction

	function automatic logic signed [erm_pkg::EW-1:0] ex(
		input logic signed [erm_pkg::TW-1:0] a);
		return erm_pkg::EW'(a);
	endfunction

	function automatic logic signed [erm_pkg::OUT_W-1:0] finish(
		input logic signed [erm_pkg::EW-1:0] v);
		logic signed [erm_pkg::EW:0] t;
		logic signed [erm_pkg::EW:0] lim;
		t   = (erm_pkg::EW'(v) + (erm_pkg::EW+1)'(erm_pkg::RND)) >>> erm_pkg::RND_SH;
		lim = (erm_pkg::EW+1)'(1) <<< (erm_pkg::FRAC_BITS + 1);
		if (t >= lim)
			t = lim - 1;
		if (t < -lim)
			t = -lim;
		return t[erm_pkg::OUT_W-1:0];
	endfunction

	// stage 1 two-factor products
	logic signed [erm_pkg::TW-1:0] cpcy_s1, cpsy_s1, crsy_s1, crcy_s1, srsy_s1, srcy_s1;
	logic signed [erm_pkg::TW-1:0] spcy_s1, spsy_s1, srsp_s1, crsp_s1, srcp_s1, crcp_s1;
	logic signed [erm_pkg::TW-1:0] sp_s1, cp_s1, cy_s1, sy_s1;
	erm_pkg::op_t op_s1, op_s2;
	// stage 2 carries stage 1 plus three-factor products
	logic signed [erm_pkg::TW-1:0] cpcy_s2, cpsy_s2, crsy_s2, crcy_s2, srsy_s2, srcy_s2;
	logic signed [erm_pkg::TW-1:0] spcy_s2, spsy_s2, srsp_s2, crsp_s2, srcp_s2, crcp_s2;
	logic signed [erm_pkg::TW-1:0] sp_s2, cp_s2;
	logic signed [erm_pkg::TW-1:0] a_s2, b_s2, c_s2, d_s2, e_s2, f_s2, g_s2, h_s2;
	logic signed [erm_pkg::EW-1:0] el_s3 [9];
	logic signed [erm_pkg::EW-1:0] el [9];

	always_ff @(posedge clk) begin
		if (en) begin
			cpcy_s1 <= qmul(cp, cy); cpsy_s1 <= qmul(cp, sy);
			crsy_s1 <= qmul(cr, sy); crcy_s1 <= qmul(cr, cy);
			srsy_s1 <= qmul(sr, sy); srcy_s1 <= qmul(sr, cy);
			spcy_s1 <= qmul(sp, cy); spsy_s1 <= qmul(sp, sy);
			srsp_s1 <= qmul(sr, sp); crsp_s1 <= qmul(cr, sp);
			srcp_s1 <= qmul(sr, cp); crcp_s1 <= qmul(cr, cp);
			sp_s1 <= sp; cp_s1 <= cp; cy_s1 <= cy; sy_s1 <= sy;
			op_s1 <= op;

			cpcy_s2 <= cpcy_s1; cpsy_s2 <= cpsy_s1; crsy_s2 <= crsy_s1;
			crcy_s2 <= crcy_s1; srsy_s2 <= srsy_s1; srcy_s2 <= srcy_s1;
			spcy_s2 <= spcy_s1; spsy_s2 <= spsy_s1; srsp_s2 <= srsp_s1;
			crsp_s2 <= crsp_s1; srcp_s2 <= srcp_s1; crcp_s2 <= crcp_s1;
			sp_s2 <= sp_s1; cp_s2 <= cp_s1; op_s2 <= op_s1;
			a_s2 <= qmul(srsp_s1, cy_s1); b_s2 <= qmul(srsp_s1, sy_s1);
			c_s2 <= qmul(crsp_s1, cy_s1); d_s2 <= qmul(crsp_s1, sy_s1);
			e_s2 <= qmul(srcp_s1, cy_s1); f_s2 <= qmul(srcp_s1, sy_s1);
			g_s2 <= qmul(crcp_s1, cy_s1); h_s2 <= qmul(crcp_s1, sy_s1);

			el_s3 <= el;
			for (int k = 0; k < 9; k++)
				m[k] <= finish(el_s3[k]);
		end
	end

	// a..h: srsp*cy, srsp*sy, crsp*cy, crsp*sy, srcp*cy, srcp*sy, crcp*cy, crcp*sy
	always_comb begin
		case (op_s2)
			erm_pkg::OP_ROT: begin
				el[0] = ex(cpcy_s2);
				el[1] = ex(cpsy_s2);
				el[2] = -ex(sp_s2);
				el[3] = -ex(crsy_s2) + ex(a_s2);
				el[4] = ex(crcy_s2) + ex(b_s2);
				el[5] = ex(srcp_s2);
				el[6] = ex(srsy_s2) + ex(c_s2);
				el[7] = -ex(srcy_s2) + ex(d_s2);
				el[8] = ex(crcp_s2);
			end
			erm_pkg::OP_DYAW: begin
				el[0] = -ex(cpsy_s2);
				el[1] = ex(cpcy_s2);
				el[2] = '0;
				el[3] = -ex(crcy_s2) - ex(b_s2);
				el[4] = -ex(crsy_s2) + ex(a_s2);
				el[5] = '0;
				el[6] = ex(srcy_s2) - ex(d_s2);
				el[7] = ex(srsy_s2) + ex(c_s2);
				el[8] = '0;
			end
			erm_pkg::OP_DPITCH: begin
				el[0] = -ex(spcy_s2);
				el[1] = -ex(spsy_s2);
				el[2] = -ex(cp_s2);
				el[3] = ex(e_s2);
				el[4] = ex(f_s2);
				el[5] = -ex(srsp_s2);
				el[6] = ex(g_s2);
				el[7] = ex(h_s2);
				el[8] = -ex(crsp_s2);
			end
			default: begin
				el[0] = '0;
				el[1] = '0;
				el[2] = '0;
				el[3] = ex(srsy_s2) + ex(c_s2);
				el[4] = -ex(srcy_s2) + ex(d_s2);
				el[5] = ex(crcp_s2);
				el[6] = ex(crsy_s2) - ex(a_s2);
				el[7] = -ex(crcy_s2) - ex(b_s2);
				el[8] = -ex(srcp_s2);
			end
		endcase
	end
endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
module tb;
	typedef logic signed [erm_pkg::OUT_W-1:0] elem_t;
	typedef struct {
		elem_t m [9];
	} mat_t;

	// Matrix predictor and scoreboard for the Euler rotation matrix unit.
	class matrix_scoreboard;
		mat_t pending[$];
		int errors;

		// arithmetic shift right, floor rounding
		static function longint sra(longint v, int s);
			return v >>> s;
		endfunction

		static function longint qmul(longint a, longint b);
			return sra(a * b + (64'sd1 <<< 29), 30);
		endfunction

		// rotation-mode CORDIC in Q30, half-turn fold for the left half plane
		static function void sincos(logic [erm_pkg::ANGLE_BITS-1:0] ang,
			output longint s, output longint c);
			logic [31:0] u;
			logic flip;
			longint x, y, z, dx, dy;
			u = {ang, {(32 - erm_pkg::ANGLE_BITS){1'b0}}};
			flip = (u[31:30] == 2'd1) || (u[31:30] == 2'd2);
			if (flip)
				u = u + 32'h8000_0000;
			x = 652032874;
			y = 0;
			z = longint'($signed(u));
			for (int i = 0; i < erm_pkg::CORDIC_STEPS; i++) begin
				dx = sra(y, i);
				dy = sra(x, i);
				if (z >= 0) begin
					x -= dx; y += dy; z -= longint'(erm_pkg::ATAN_TURNS[i]);
				end else begin
					x += dx; y -= dy; z += longint'(erm_pkg::ATAN_TURNS[i]);
				end
			end
			if (flip) begin
				x = -x; y = -y;
			end
			s = y;
			c = x;
		endfunction

		static function elem_t round_sat(longint v);
			longint lim;
			lim = 64'sd1 <<< (erm_pkg::FRAC_BITS + 1);
			if (erm_pkg::RND_SH > 0)
				v = sra(v + erm_pkg::RND, erm_pkg::RND_SH);
			if (v >= lim) v = lim - 1;
			if (v < -lim) v = -lim;
			return elem_t'(v);
		endfunction

		function void note_request(erm_pkg::op_t op, logic [15:0] yaw, logic [15:0] pitch,
			logic [15:0] roll);
			longint sy, cy, sp, cp, sr, cr;
			longint m [9];
			mat_t e;
			sincos(yaw, sy, cy);
			sincos(pitch, sp, cp);
			sincos(roll, sr, cr);
			case (op)
				erm_pkg::OP_ROT: begin
					m[0] = qmul(cp, cy);
					m[1] = qmul(cp, sy);
					m[2] = -sp;
					m[3] = -qmul(cr, sy) + qmul(qmul(sr, sp), cy);
					m[4] = qmul(cr, cy) + qmul(qmul(sr, sp), sy);
					m[5] = qmul(sr, cp);
					m[6] = qmul(sr, sy) + qmul(qmul(cr, sp), cy);
					m[7] = -qmul(sr, cy) + qmul(qmul(cr, sp), sy);
					m[8] = qmul(cr, cp);
				end
				erm_pkg::OP_DYAW: begin
					m[0] = -qmul(cp, sy);
					m[1] = qmul(cp, cy);
					m[2] = 0;
					m[3] = -qmul(cr, cy) - qmul(qmul(sr, sp), sy);
					m[4] = -qmul(cr, sy) + qmul(qmul(sr, sp), cy);
					m[5] = 0;
					m[6] = qmul(sr, cy) - qmul(qmul(cr, sp), sy);
					m[7] = qmul(sr, sy) + qmul(qmul(cr, sp), cy);
					m[8] = 0;
				end
				erm_pkg::OP_DPITCH: begin
					m[0] = -qmul(sp, cy);
					m[1] = -qmul(sp, sy);
					m[2] = -cp;
					m[3] = qmul(qmul(sr, cp), cy);
					m[4] = qmul(qmul(sr, cp), sy);
					m[5] = -qmul(sr, sp);
					m[6] = qmul(qmul(cr, cp), cy);
					m[7] = qmul(qmul(cr, cp), sy);
					m[8] = -qmul(cr, sp);
				end
				default: begin
					m[0] = 0;
					m[1] = 0;
					m[2] = 0;
					m[3] = qmul(sr, sy) + qmul(qmul(cr, sp), cy);
					m[4] = -qmul(sr, cy) + qmul(qmul(cr, sp), sy);
					m[5] = qmul(cr, cp);
					m[6] = qmul(cr, sy) - qmul(qmul(sr, sp), cy);
					m[7] = -qmul(cr, cy) - qmul(qmul(sr, sp), sy);
					m[8] = -qmul(sr, cp);
				end
			endcase
			for (int k = 0; k < 9; k++)
				e.m[k] = round_sat(m[k]);
			pending.push_back(e);
		endfunction

		function void check_matrix(mat_t got);
			mat_t e;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected matrix at %0t", $realtime);
				return;
			end
			e = pending.pop_front();
			for (int k = 0; k < 9; k++)
				if (got.m[k] !== e.m[k]) begin
					errors++;
					if (errors <= 10)
						$display("m%0d%0d: expected %0d, got %0d", k / 3, k % 3,
							e.m[k], got.m[k]);
				end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	erm_in_if angles ();
	erm_out_if matrix ();

	euler_rotation_matrix_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.angles(angles.sink),
		.matrix(matrix.source)
	);

	matrix_scoreboard sb;
	longint cycles = 0;
	// no idling on either side once this is set
	bit steady;

	localparam longint CYCLE_LIMIT = 200000;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb failed");
			$finish;
		end
	end

	// collect requests and results at the clock edge
	always @(posedge clk) begin
		mat_t got;
		if (arst_n && angles.valid && angles.ready)
			sb.note_request(erm_pkg::op_t'(angles.operation), angles.yaw, angles.pitch,
				angles.roll);
		if (arst_n && matrix.valid && matrix.ready) begin
			got.m[0] = matrix.m00; got.m[1] = matrix.m01; got.m[2] = matrix.m02;
			got.m[3] = matrix.m10; got.m[4] = matrix.m11; got.m[5] = matrix.m12;
			got.m[6] = matrix.m20; got.m[7] = matrix.m21; got.m[8] = matrix.m22;
			sb.check_matrix(got);
		end
	end

	// result side: ready low in random bursts until steady is set
	initial begin
		int n;
		matrix.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!steady && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 3);
				matrix.ready <= 1'b0;
				repeat (n - 1) @(posedge clk);
			end else begin
				matrix.ready <= 1'b1;
			end
		end
	end

	function automatic logic [15:0] rand_angle();
		case ($urandom_range(0, 3))
			0: return 16'(16'h8000 + $urandom_range(0, 2) - 1);
			1: return 16'({$urandom_range(0, 7), 13'd0});
			default: return 16'($urandom);
		endcase
	endfunction

	// one request; holds valid until accepted, optional gap afterwards
	task automatic send_request(erm_pkg::op_t op, logic [15:0] y, logic [15:0] p,
		logic [15:0] r);
		angles.valid <= 1'b1;
		angles.operation <= op;
		angles.yaw <= y;
		angles.pitch <= p;
		angles.roll <= r;
		do @(posedge clk); while (!angles.ready);
		if (!steady && $urandom_range(0, 4) == 0) begin
			angles.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	task automatic drain();
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	initial begin
		logic [15:0] edges [6];
		sb = new();
		steady = 0;
		arst_n = 1'b0;
		angles.valid = 1'b0;
		angles.operation = erm_pkg::OP_ROT;
		angles.yaw = '0;
		angles.pitch = '0;
		angles.roll = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: every operation at zero, the field extremes and minus pi
		edges = '{16'h0000, 16'h7fff, 16'h8000, 16'h4000, 16'hc000, 16'hffff};
		for (int o = 0; o < 4; o++) begin
			send_request(erm_pkg::op_t'(o), 16'h0000, 16'h0000, 16'h0000);
			send_request(erm_pkg::op_t'(o), 16'h8000, 16'h8000, 16'h8000);
			send_request(erm_pkg::op_t'(o), 16'h7fff, 16'h4000, 16'hc000);
		end
		for (int k = 0; k < 6; k++)
			send_request(erm_pkg::op_t'(k % 4), edges[k], edges[(k + 2) % 6],
				edges[(k + 4) % 6]);
		send_request(erm_pkg::OP_DPITCH, 16'h5555, 16'haaaa, 16'h5555);

		// sender holds off until the pipeline has emptied
		angles.valid <= 1'b0;
		drain();

		for (int i = 0; i < 1900; i++) begin
			if (i == 1000) begin
				angles.valid <= 1'b0;
				drain();
			end
			if (i == 1600)
				steady = 1;
			send_request(erm_pkg::op_t'($urandom_range(0, 3)), rand_angle(), rand_angle(),
				rand_angle());
		end
		angles.valid <= 1'b0;
		drain();
		repeat (erm_pkg::LAT + 10) @(posedge clk);

		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end
endmodule
